// ----- hdl/lcdt_pkg.sv -----
// Shared types and constants for the LCD mode timing controller.
package lcdt_pkg;

  // Widths fixed by the register and field definitions
  localparam int ResW  = 10;
  localparam int AccW  = ResW + 1;
  localparam int TickW = 7;
  localparam int LineW = 8;
  localparam int ModeW = 2;
  localparam int LcW   = 8;
  localparam int IrqW  = 4;

  localparam logic [ResW-1:0] RES_MAX = {ResW{1'b1}};

  // Configuration register indexes
  localparam logic [1:0] REG_DISPLAY_ENABLE = 2'd0;
  localparam logic [1:0] REG_LINE_COMPARE   = 2'd1;
  localparam logic [1:0] REG_IRQ_ENABLES    = 2'd2;

  // STAT enable bits
  localparam int IRQ_HBLANK = 0;
  localparam int IRQ_VBLANK = 1;
  localparam int IRQ_OAM    = 2;
  localparam int IRQ_COINC  = 3;

  // Display mode codes as seen on the result
  localparam logic [ModeW-1:0] DISP_HBLANK = 2'd0;
  localparam logic [ModeW-1:0] DISP_VBLANK = 2'd1;
  localparam logic [ModeW-1:0] DISP_OAM    = 2'd2;
  localparam logic [ModeW-1:0] DISP_DRAW   = 2'd3;

  // Mode state machine
  typedef enum logic [3:0] {
    MODE_HBLANK = 4'b0001,
    MODE_VBLANK = 4'b0010,
    MODE_OAM    = 4'b0100,
    MODE_DRAW   = 4'b1000
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic [ResW-1:0]    residual;
    logic [LineW-1:0]   line;
    logic               coinc;
  } lcdt_state_t;

  typedef struct packed {
    logic               display_enable;
    logic [LcW-1:0]     line_compare;
    logic [IrqW-1:0]    irq_enables;
  } lcdt_cfg_t;

  typedef struct packed {
    logic [ModeW-1:0]   display_mode;
    logic [LineW-1:0]   line_number;
    logic               coincidence;
    logic               stat_irq;
    logic               vblank_irq;
    logic               render_line;
    logic               frame_done;
  } lcdt_result_t;

  // One-hot state to output code
  function automatic logic [ModeW-1:0] mode_code(input mode_t m);
    logic [ModeW-1:0] c;
    case (m)
      MODE_HBLANK: c = DISP_HBLANK;
      MODE_VBLANK: c = DISP_VBLANK;
      MODE_OAM:    c = DISP_OAM;
      MODE_DRAW:   c = DISP_DRAW;
      default:     c = DISP_HBLANK;
    endcase
    return c;
  endfunction

  // Clamp an accumulated count into the residual register
  function automatic logic [ResW-1:0] sat_res(input logic [AccW-1:0] v);
    logic [ResW-1:0] r;
    r = v[AccW-1] ? RES_MAX : v[ResW-1:0];
    return r;
  endfunction

endpackage

// ----- hdl/lcdt_step.sv -----
// Next-state and result logic for one tick-count word.
module lcdt_step
  import lcdt_pkg::*;
#(
  parameter int OAM_TICKS     = 80,
  parameter int DRAW_TICKS    = 172,
  parameter int HBLANK_TICKS  = 204,
  parameter int LINE_TICKS    = 456,
  parameter int VISIBLE_LINES = 144,
  parameter int LAST_LINE     = 152
) (
  input  lcdt_state_t       cur,
  input  lcdt_cfg_t         cfg,
  input  logic [TickW-1:0]  tick,
  output lcdt_state_t       nxt,
  output lcdt_result_t      res
);

  logic [AccW-1:0]  accum;
  logic [AccW-1:0]  thr;
  logic [AccW-1:0]  diff;
  logic             over;
  logic [ResW-1:0]  res_next;
  logic [LineW-1:0] line_inc;
  logic             hit_inc;
  logic             hit_zero;
  logic             coinc_en;
  logic             stat;
  logic             vbl;
  logic             render;
  logic             frame;

  // Residual accumulate, threshold compare and subtract
  assign accum = {1'b0, cur.residual} + {{(AccW-TickW){1'b0}}, tick};

  always_comb begin
    case (cur.mode)
      MODE_OAM:    thr = AccW'(OAM_TICKS);
      MODE_DRAW:   thr = AccW'(DRAW_TICKS);
      MODE_VBLANK: thr = AccW'(LINE_TICKS);
      MODE_HBLANK: thr = AccW'(HBLANK_TICKS);
      default:     thr = AccW'(HBLANK_TICKS);
    endcase
  end

  assign over     = (accum >= thr);
  assign diff     = accum - thr;
  assign res_next = over ? sat_res(diff) : sat_res(accum);

  // Line compares
  assign line_inc = cur.line + LineW'(1);
  assign hit_inc  = (cfg.line_compare == line_inc);
  assign hit_zero = (cfg.line_compare == '0);
  assign coinc_en = cfg.irq_enables[IRQ_COINC];

  // Mode transitions
  always_comb begin
    nxt    = cur;
    stat   = 1'b0;
    vbl    = 1'b0;
    render = 1'b0;
    frame  = 1'b0;
    if (!cfg.display_enable) begin
      nxt.mode     = MODE_HBLANK;
      nxt.line     = '0;
      nxt.residual = '0;
    end else begin
      nxt.residual = res_next;
      if (over) begin
        case (cur.mode)
          MODE_VBLANK: begin
            if (cur.line == '0) begin
              nxt.coinc = hit_zero;
              stat      = (hit_zero & coinc_en) | cfg.irq_enables[IRQ_OAM];
              nxt.mode  = MODE_OAM;
            end else if (cur.line == LineW'(LAST_LINE)) begin
              // wrap: compare the momentary line, then line 0
              nxt.line  = '0;
              nxt.coinc = hit_zero;
              stat      = (hit_inc | hit_zero) & coinc_en;
            end else begin
              nxt.line  = line_inc;
              nxt.coinc = hit_inc;
              stat      = hit_inc & coinc_en;
            end
          end
          MODE_OAM: begin
            nxt.mode = MODE_DRAW;
          end
          MODE_DRAW: begin
            nxt.mode = MODE_HBLANK;
            stat     = cfg.irq_enables[IRQ_HBLANK];
            render   = 1'b1;
          end
          MODE_HBLANK: begin
            nxt.line  = line_inc;
            nxt.coinc = hit_inc;
            if (line_inc == LineW'(VISIBLE_LINES)) begin
              nxt.mode = MODE_VBLANK;
              stat     = (hit_inc & coinc_en) | cfg.irq_enables[IRQ_VBLANK];
              vbl      = 1'b1;
              frame    = 1'b1;
            end else begin
              nxt.mode = MODE_OAM;
              stat     = (hit_inc & coinc_en) | cfg.irq_enables[IRQ_OAM];
            end
          end
          default: begin
            nxt.mode = MODE_HBLANK;
          end
        endcase
      end
    end
  end

  // Result word
  always_comb begin
    res.display_mode = mode_code(nxt.mode);
    res.line_number  = nxt.line;
    res.coincidence  = nxt.coinc;
    res.stat_irq     = stat;
    res.vblank_irq   = vbl;
    res.render_line  = render;
    res.frame_done   = frame;
  end

endmodule

// ----- hdl/lcd_mode_timing_controller_unit.sv -----
// Top level of the LCD mode and line timing controller.
// Usage:
//   Input channel: one tick-count word per handshake (in_valid / in_stall),
//   taken when in_valid is high and in_stall is low.
//   Result channel: one result word per input word (out_valid / out_stall),
//   carrying mode, line, coincidence flag and the per-step strobes.
//   Config port: APB-style, byte addresses 0 (display enable), 4 (line
//   compare), 8 (STAT enables). pready is tied high. Write only while idle.
// Pipeline: a word is registered in the entry stage on acceptance, and its
//   result is registered in the result stage as the word leaves the entry
//   stage, so the out_ ports are driven from registers.
// Throughput: one word per cycle while the result stage is free, set by the
//   loop through the residual/mode/line state registers.
// Reset: rst_n is synchronous, active low; it clears the timing state to
//   HBlank on line 0, clears all config registers and empties both stages.
// Stall: while out_stall holds a pending result, the entry stage keeps its
//   word; in_stall rises only when both stages are full.
module lcd_mode_timing_controller_unit
  import lcdt_pkg::*;
#(
  parameter int OAM_TICKS     = 80,
  parameter int DRAW_TICKS    = 172,
  parameter int HBLANK_TICKS  = 204,
  parameter int LINE_TICKS    = 456,
  parameter int VISIBLE_LINES = 144,
  parameter int LAST_LINE     = 152
) (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [TickW-1:0]  in_tick_count,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ModeW-1:0]  out_display_mode,
  output logic [LineW-1:0]  out_line_number,
  output logic              out_coincidence,
  output logic              out_stat_irq,
  output logic              out_vblank_irq,
  output logic              out_render_line,
  output logic              out_frame_done,
  // config port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [3:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  lcdt_cfg_t        cfg_r;
  lcdt_state_t      st_r;
  lcdt_state_t      st_nxt;
  lcdt_result_t     step_res;
  lcdt_result_t     out_r;
  logic             s1_valid_r;
  logic [TickW-1:0] s1_tick_r;
  logic             out_valid_r;
  logic             out_free;
  logic             s1_move;
  logic             cfg_wr;
  logic [1:0]       cfg_idx;

  // Config register file
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DISPLAY_ENABLE: cfg_r.display_enable <= cfg_pwdata[0];
        REG_LINE_COMPARE:   cfg_r.line_compare   <= cfg_pwdata[LcW-1:0];
        REG_IRQ_ENABLES:    cfg_r.irq_enables    <= cfg_pwdata[IrqW-1:0];
        default:            cfg_r <= cfg_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DISPLAY_ENABLE: cfg_prdata = {31'd0, cfg_r.display_enable};
      REG_LINE_COMPARE:   cfg_prdata = {{(32-LcW){1'b0}}, cfg_r.line_compare};
      REG_IRQ_ENABLES:    cfg_prdata = {{(32-IrqW){1'b0}}, cfg_r.irq_enables};
      default:            cfg_prdata = '0;
    endcase
  end

  // Handshake control
  assign out_free = ~out_valid_r | ~out_stall;
  assign s1_move  = s1_valid_r & out_free;
  assign in_stall = s1_valid_r & ~out_free;

  // Entry stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_tick_r <= in_tick_count;
    end
  end

  // Step logic
  lcdt_step #(
    .OAM_TICKS     (OAM_TICKS),
    .DRAW_TICKS    (DRAW_TICKS),
    .HBLANK_TICKS  (HBLANK_TICKS),
    .LINE_TICKS    (LINE_TICKS),
    .VISIBLE_LINES (VISIBLE_LINES),
    .LAST_LINE     (LAST_LINE)
  ) u_step (
    .cur  (st_r),
    .cfg  (cfg_r),
    .tick (s1_tick_r),
    .nxt  (st_nxt),
    .res  (step_res)
  );

  // Timing state, updated as each word leaves the entry stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode     <= MODE_HBLANK;
      st_r.residual <= '0;
      st_r.line     <= '0;
      st_r.coinc    <= 1'b0;
    end else if (s1_move) begin
      st_r <= st_nxt;
    end
  end

  // Result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_r <= step_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_display_mode = out_r.display_mode;
  assign out_line_number  = out_r.line_number;
  assign out_coincidence  = out_r.coincidence;
  assign out_stat_irq     = out_r.stat_irq;
  assign out_vblank_irq   = out_r.vblank_irq;
  assign out_render_line  = out_r.render_line;
  assign out_frame_done   = out_r.frame_done;

endmodule

// ----- tb/sv/lcd_mode_timing_controller_unit_test.sv -----
// Self-checking testbench for the LCD mode and line timing controller.
module lcd_mode_timing_controller_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lcdt_pkg::*;

  // Timing constants, matching the block's default parameters
  localparam int OAM_LEN     = 80;
  localparam int DRAW_LEN    = 172;
  localparam int HBLANK_LEN  = 204;
  localparam int LINE_LEN    = 456;
  localparam int VIS_LINES   = 144;
  localparam int LAST_LINE_N = 152;
  localparam int RES_CAP     = 1023;

  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RAND_WORDS    = 650;

  // Directed plan: either a tick word or a register write
  typedef enum logic {ROW_TICK, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t    kind;
    logic [1:0]   reg_idx;
    logic [7:0]   value;
    logic         pinned;
    lcdt_result_t res;
  } plan_row_t;

  typedef struct {
    int           idx;
    lcdt_result_t res;
  } pin_t;

  localparam int PLAN_LEN = 27;

  plan_row_t dir_plan [PLAN_LEN] = '{
    // display off out of reset: everything reads zero
    '{ROW_TICK, REG_DISPLAY_ENABLE, 8'd0,   1'b1, '0},
    '{ROW_TICK, REG_DISPLAY_ENABLE, 8'd127, 1'b1, '0},
    '{ROW_REG,  REG_LINE_COMPARE,   8'd1,   1'b0, '0},
    '{ROW_REG,  REG_IRQ_ENABLES,    8'd15,  1'b0, '0},
    '{ROW_REG,  REG_DISPLAY_ENABLE, 8'd1,   1'b0, '0},
    // HBlank ends exactly at threshold, line 1 matches compare
    '{ROW_TICK, REG_DISPLAY_ENABLE, 8'd127, 1'b0, '0},
    '{ROW_TICK, REG_DISPLAY_ENABLE, 8'd77,  1'b0, '0},
    // OAM one short, then exact
    '{ROW_TICK, REG_DISPLAY_ENABLE, 8'd79,  1'b0, '0},
    '{ROW_TICK, REG_DISPLAY_ENABLE, 8'd1,   1'b0, '0},
    // draw one short, then exact (render strobe)
    '{ROW_TICK, REG_DISPLAY_ENABLE, 8'd127, 1'b0, '0},
    '{ROW_TICK, REG_DISPLAY_ENABLE, 8'd44,  1'b0, '0},
    '{ROW_TICK, REG_DISPLAY_ENABLE, 8'd1,   1'b0, '0},
    // overshoot carries into the next mode
    '{ROW_TICK, REG_DISPLAY_ENABLE, 8'd127, 1'b0, '0},
    '{ROW_TICK, REG_DISPLAY_ENABLE, 8'd127, 1'b0, '0},
    '{ROW_TICK, REG_DISPLAY_ENABLE, 8'd127, 1'b0, '0},
    '{ROW_TICK, REG_DISPLAY_ENABLE, 8'd80,  1'b0, '0},
    '{ROW_TICK, REG_DISPLAY_ENABLE, 8'd0,   1'b0, '0},
    // display off mid-line forces mode/line to zero, flag was already clear
    '{ROW_REG,  REG_DISPLAY_ENABLE, 8'd0,   1'b0, '0},
    '{ROW_TICK, REG_DISPLAY_ENABLE, 8'd100, 1'b1, '0},
    '{ROW_REG,  REG_LINE_COMPARE,   8'd255, 1'b0, '0},
    '{ROW_REG,  REG_IRQ_ENABLES,    8'd0,   1'b0, '0},
    '{ROW_REG,  REG_DISPLAY_ENABLE, 8'd1,   1'b0, '0},
    '{ROW_TICK, REG_DISPLAY_ENABLE, 8'd85,  1'b0, '0},
    '{ROW_TICK, REG_DISPLAY_ENABLE, 8'd42,  1'b0, '0},
    '{ROW_TICK, REG_DISPLAY_ENABLE, 8'd127, 1'b0, '0},
    '{ROW_TICK, REG_DISPLAY_ENABLE, 8'd127, 1'b0, '0},
    '{ROW_TICK, REG_DISPLAY_ENABLE, 8'd127, 1'b0, '0}
  };

  logic              clk;
  logic              rst_n         = 1'b0;
  logic              in_valid      = 1'b0;
  logic              in_stall;
  logic [TickW-1:0]  in_tick_count = '0;
  logic              out_valid;
  logic              out_stall     = 1'b0;
  logic [ModeW-1:0]  out_display_mode;
  logic [LineW-1:0]  out_line_number;
  logic              out_coincidence;
  logic              out_stat_irq;
  logic              out_vblank_irq;
  logic              out_render_line;
  logic              out_frame_done;
  logic              cfg_psel      = 1'b0;
  logic              cfg_penable   = 1'b0;
  logic              cfg_pwrite    = 1'b0;
  logic [3:0]        cfg_paddr     = '0;
  logic [31:0]       cfg_pwdata    = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  lcd_mode_timing_controller_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_tick_count    (in_tick_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_display_mode (out_display_mode),
    .out_line_number  (out_line_number),
    .out_coincidence  (out_coincidence),
    .out_stat_irq     (out_stat_irq),
    .out_vblank_irq   (out_vblank_irq),
    .out_render_line  (out_render_line),
    .out_frame_done   (out_frame_done),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  // Register mirror
  logic             cfg_on   = 1'b0;
  logic [LcW-1:0]   cmp_line = '0;
  logic [IrqW-1:0]  stat_en  = '0;

  // Timing state mirror
  logic [ModeW-1:0] tm_mode  = DISP_HBLANK;
  logic [LineW-1:0] tm_line  = '0;
  logic [ResW-1:0]  tm_res   = '0;
  logic             tm_coinc = 1'b0;

  lcdt_result_t status_due [$];
  pin_t         pinned_q [$];

  int  errors       = 0;
  int  cycles       = 0;
  int  words_issued = 0;
  int  words_taken  = 0;
  int  words_seen   = 0;
  int  frames_done  = 0;
  int  wraps        = 0;
  int  coinc_hits   = 0;
  bit  quiet        = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Residual register clamps at its full-scale value
  function automatic logic [ResW-1:0] clamp_res(input logic [AccW-1:0] v);
    return (v > RES_CAP) ? ResW'(RES_CAP) : v[ResW-1:0];
  endfunction

  // Refresh the coincidence flag; returns the STAT request it causes
  function automatic logic match_line(input logic [LineW-1:0] ln);
    tm_coinc = (cmp_line == ln);
    if (tm_coinc) coinc_hits++;
    return tm_coinc & stat_en[IRQ_COINC];
  endfunction

  // One step of mode/line timing for an accepted tick word
  function automatic lcdt_result_t advance_lcd_timing(input logic [TickW-1:0] ticks);
    logic [AccW-1:0]  acc;
    logic [LineW-1:0] nxt;
    lcdt_result_t     r;
    acc = AccW'(tm_res) + AccW'(ticks);
    r = '0;
    if (!cfg_on) begin
      tm_mode = DISP_HBLANK;
      tm_line = '0;
      tm_res  = '0;
    end else begin
      case (tm_mode)
        DISP_VBLANK: begin
          if (acc >= LINE_LEN) begin
            tm_res = clamp_res(acc - AccW'(LINE_LEN));
            if (tm_line == 0) begin
              // last VBlank line (line 0) ends: start of a new frame
              r.stat_irq |= match_line('0);
              if (stat_en[IRQ_OAM]) r.stat_irq = 1'b1;
              tm_mode = DISP_OAM;
            end else begin
              nxt = tm_line + 1'b1;
              r.stat_irq |= match_line(nxt);
              if (tm_line == LAST_LINE_N) begin
                // momentary line past the last one, then wrap to line 0
                tm_line = '0;
                r.stat_irq |= match_line('0);
                wraps++;
              end else begin
                tm_line = nxt;
              end
            end
          end else begin
            tm_res = clamp_res(acc);
          end
        end
        DISP_OAM: begin
          if (acc >= OAM_LEN) begin
            tm_res  = clamp_res(acc - AccW'(OAM_LEN));
            tm_mode = DISP_DRAW;
          end else begin
            tm_res = clamp_res(acc);
          end
        end
        DISP_DRAW: begin
          if (acc >= DRAW_LEN) begin
            tm_res = clamp_res(acc - AccW'(DRAW_LEN));
            if (stat_en[IRQ_HBLANK]) r.stat_irq = 1'b1;
            tm_mode = DISP_HBLANK;
            r.render_line = 1'b1;
          end else begin
            tm_res = clamp_res(acc);
          end
        end
        default: begin
          if (acc >= HBLANK_LEN) begin
            tm_res  = clamp_res(acc - AccW'(HBLANK_LEN));
            tm_line = tm_line + 1'b1;
            r.stat_irq |= match_line(tm_line);
            if (tm_line == VIS_LINES) begin
              if (stat_en[IRQ_VBLANK]) r.stat_irq = 1'b1;
              tm_mode = DISP_VBLANK;
              r.vblank_irq = 1'b1;
              r.frame_done = 1'b1;
              frames_done++;
            end else begin
              if (stat_en[IRQ_OAM]) r.stat_irq = 1'b1;
              tm_mode = DISP_OAM;
            end
          end else begin
            tm_res = clamp_res(acc);
          end
        end
      endcase
    end
    r.display_mode = tm_mode;
    r.line_number  = tm_line;
    r.coincidence  = tm_coinc;
    return r;
  endfunction

  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      errors++;
    end
  endtask

  // Result checking, then prediction for the word taken at this edge
  always @(posedge clk) begin
    lcdt_result_t want;
    pin_t         pin_hit;
    if (rst_n && out_valid && !out_stall) begin
      words_seen++;
      if (status_due.size() == 0) begin
        $error("status word with nothing pending");
        errors++;
      end else begin
        want = status_due.pop_front();
        check_field("display_mode", want.display_mode, out_display_mode);
        check_field("line_number",  want.line_number,  out_line_number);
        check_field("coincidence",  want.coincidence,  out_coincidence);
        check_field("stat_irq",     want.stat_irq,     out_stat_irq);
        check_field("vblank_irq",   want.vblank_irq,   out_vblank_irq);
        check_field("render_line",  want.render_line,  out_render_line);
        check_field("frame_done",   want.frame_done,   out_frame_done);
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      want = advance_lcd_timing(in_tick_count);
      if (pinned_q.size() != 0 && pinned_q[0].idx == words_taken) begin
        pin_hit = pinned_q.pop_front();
        want    = pin_hit.res;
      end
      status_due.push_back(want);
      words_taken++;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver back-pressure: mostly short stalls, a few long ones
  initial begin
    forever begin
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      if (!quiet) begin
        out_stall <= 1'b1;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(8, 40)) @(posedge clk);
        else repeat ($urandom_range(1, 3)) @(posedge clk);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Mostly large counts so lines advance quickly; some small and boundary ones
  function automatic logic [TickW-1:0] pick_tick();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return TickW'($urandom_range(96, 127));
    if (r < 85) return TickW'($urandom_range(0, 127));
    if (r < 95) return TickW'($urandom_range(0, 4));
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return TickW'(79);
      2:       return TickW'(80);
      default: return '1;
    endcase
  endfunction

  task automatic send_tick(input logic [TickW-1:0] t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_tick_count <= t;
    words_issued++;
    do @(posedge clk); while (in_stall);
  endtask

  // Hold the sender until every pending status word is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (status_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write followed by a read-back of the same register
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] rd;
    logic [31:0] want;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_DISPLAY_ENABLE: cfg_on   = val[0];
      REG_LINE_COMPARE:   cmp_line = val[LcW-1:0];
      default:            stat_en  = val[IrqW-1:0];
    endcase
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_DISPLAY_ENABLE: begin
        want = 32'(cfg_on);
        rd   = 32'(rd[0]);
      end
      REG_LINE_COMPARE: begin
        want = 32'(cmp_line);
        rd   = 32'(rd[LcW-1:0]);
      end
      default: begin
        want = 32'(stat_en);
        rd   = 32'(rd[IrqW-1:0]);
      end
    endcase
    check_field("register read-back", want, rd);
  endtask

  initial begin
    int          rand_words;
    int          phase_len;
    logic        on_next;
    logic [7:0]  lc_next;
    pin_t        pin;

    rand_words = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed plan
    foreach (dir_plan[i]) begin
      if (dir_plan[i].kind == ROW_REG) begin
        wait_drained();
        write_reg(dir_plan[i].reg_idx, 32'(dir_plan[i].value));
      end else begin
        if (dir_plan[i].pinned) begin
          pin.idx = words_issued;
          pin.res = dir_plan[i].res;
          pinned_q.push_back(pin);
        end
        send_tick(dir_plan[i].value[TickW-1:0]);
      end
    end

    // Random phases until enough words have gone through with the display on
    while (rand_words < RAND_WORDS) begin
      wait_drained();
      quiet   = ($urandom_range(0, 3) == 0);
      on_next = ($urandom_range(0, 9) != 0);
      case ($urandom_range(0, 6))
        0:       lc_next = 8'd0;
        1:       lc_next = 8'd255;
        2:       lc_next = 8'(LAST_LINE_N);
        3:       lc_next = 8'(LAST_LINE_N + 1);
        4:       lc_next = 8'(VIS_LINES);
        5:       lc_next = 8'($urandom_range(0, LAST_LINE_N + 1));
        default: lc_next = 8'($urandom_range(0, 255));
      endcase
      write_reg(REG_LINE_COMPARE, 32'(lc_next));
      write_reg(REG_IRQ_ENABLES,
                ($urandom_range(0, 3) == 0) ? 32'hf : 32'($urandom_range(0, 15)));
      write_reg(REG_DISPLAY_ENABLE, 32'(on_next));
      phase_len = on_next ? $urandom_range(60, 200) : $urandom_range(3, 8);
      repeat (phase_len) begin
        if ($urandom_range(0, 49) == 0) wait_drained();
        send_tick(pick_tick());
        if (on_next) rand_words++;
      end
    end

    wait_drained();
    $display("Summary: %0d tick words sent, %0d status words returned",
             words_issued, words_seen);
    $display("Summary: %0d frames finished, %0d wraps to line 0, %0d line matches",
             frames_done, wraps, coinc_hits);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
